[sv/slui_pkg.sv]
// ----------------------------------------------------------------------------
// slui_pkg
// Shared types and constants for the slew-limited unicycle integrator:
// sequencer states, register indexes, sine polynomial coefficients.
// ----------------------------------------------------------------------------
package slui_pkg;

  // Quarter-wave sine resolution: heading phase bits used as table index
  localparam int SINE_TABLE_BITS = 10;
  localparam int IDX_W           = SINE_TABLE_BITS + 1;
  localparam logic [IDX_W-1:0] SINE_N = IDX_W'(1) << SINE_TABLE_BITS;

  // Index scaling into Q30 and of the squared index back into Q30
  localparam int X_SHL  = 30 - SINE_TABLE_BITS;
  localparam int X2_SHL = 60 - 2 * SINE_TABLE_BITS;

  // Sine polynomial coefficients, Q30
  localparam logic [31:0] Q30_A = 32'd1686629713;
  localparam logic [31:0] Q30_B = 32'd688904866;
  localparam logic [31:0] Q30_C = 32'd76016977;

  // Largest sine magnitude in Q1.15
  localparam logic [14:0] TRIG_MAX = 15'd32767;

  // Quarter turn in binary angle units
  localparam logic [15:0] QUARTER = 16'h4000;

  // Shared multiplier operand and product widths
  localparam int MUL_W  = 33;
  localparam int PROD_W = 64;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPEED_STEP  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TURN_STEP   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TICK_SECONDS = 2'd2;

  // Configuration reset values
  localparam logic [14:0] SPEED_STEP_RST   = 15'd51;
  localparam logic [18:0] TURN_STEP_RST    = 19'd1043;
  localparam logic [15:0] TICK_SECONDS_RST = 16'd655;

  // Sequencer states: load states set the multiplier operands, the
  // following wait state lets the product settle into its register
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_HMUL,
    ST_HUPD,
    ST_IDX,
    ST_SQ,
    ST_LDC,
    ST_MC,
    ST_LDB,
    ST_MB,
    ST_LDA,
    ST_MA,
    ST_LDR,
    ST_MR,
    ST_LDV,
    ST_MV,
    ST_LDT,
    ST_MT,
    ST_POS,
    ST_OUT
  } state_t;

endpackage

[sv/slew_limited_unicycle_integrator.sv]
// ----------------------------------------------------------------------------
// slew_limited_unicycle_integrator
// Dead reckoning for a unicycle model: slew-limited speed and turn rate,
// heading integration and saturating x/y integration, one pose per tick.
// ----------------------------------------------------------------------------
// One tick is accepted on the input stream, and its pose is later shown on the
// output stream; the next tick is taken only once the sequencer is back in idle,
// which waits for the output register to be free. All products go through
// one registered 33x33 signed multiplier under a small sequencer: one for
// the heading step, then per axis five for the sine polynomial, and two for
// speed * trig * tick length. Each product has an operand load state and a
// multiply state. A finished pose waits in the output register, so a new tick
// can be accepted while it is still pending.
module slew_limited_unicycle_integrator (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream: tdata = target_speed[15:0], target_turn[35:16], zero pad
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [39:0]                        in_tdata,
  // Result stream: tdata = out_x[31:0], out_y[63:32], out_heading[79:64],
  //   out_speed[95:80], out_turn[115:96], zero pad
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [119:0]                       out_tdata,
  // Configuration write port
  input  logic                               cfg_wr_en,
  input  logic [slui_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [18:0]                        cfg_wdata
);

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [slui_pkg::MUL_W-1:0] uext(input logic [31:0] v);
    return $signed({1'b0, v});
  endfunction

  function automatic logic signed [slui_pkg::MUL_W-1:0] sext(input logic [31:0] v);
    return $signed({v[31], v});
  endfunction

  // Move cur toward tgt by at most step, never past it
  function automatic logic [21:0] slew(input logic signed [21:0] cur,
                                       input logic signed [21:0] tgt,
                                       input logic signed [21:0] step);
    logic signed [21:0] n;
    logic [21:0]        res;
    n   = cur;
    res = cur;
    if (tgt > cur) begin
      n   = cur + step;
      res = (n > tgt) ? tgt : n;
    end else if (tgt < cur) begin
      n   = cur - step;
      res = (n < tgt) ? tgt : n;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  slui_pkg::state_t state_r, state_nxt;

  logic [14:0] speed_step_r, speed_step_nxt;
  logic [18:0] turn_step_r, turn_step_nxt;
  logic [15:0] tick_r, tick_nxt;

  logic signed [31:0] pos_x_r, pos_x_nxt;
  logic signed [31:0] pos_y_r, pos_y_nxt;
  logic [15:0]        heading_r, heading_nxt;
  logic [15:0]        speed_r, speed_nxt;
  logic [19:0]        turn_r, turn_nxt;

  logic               axis_r, axis_nxt;   // 0: x (cosine), 1: y (sine)
  logic               neg_r, neg_nxt;
  logic [30:0]        x_r, x_nxt;
  logic [30:0]        x2_r, x2_nxt;

  logic signed [slui_pkg::MUL_W-1:0]  a_r, a_nxt;
  logic signed [slui_pkg::MUL_W-1:0]  b_r, b_nxt;
  logic signed [slui_pkg::PROD_W-1:0] p_r;
  logic signed [2*slui_pkg::MUL_W-1:0] prod;

  logic         out_tvalid_r, out_tvalid_nxt;
  logic [119:0] out_tdata_r, out_tdata_nxt;

  // --------------------------------------------------------------------------
  // Datapath terms
  // --------------------------------------------------------------------------
  logic                             in_xfer;
  logic [15:0]                      angle;
  logic [slui_pkg::SINE_TABLE_BITS-1:0] phase;
  logic [slui_pkg::IDX_W-1:0]       idx;
  logic [93:0]                      sq_ext;
  logic [30:0]                      x2_w;
  logic [31:0]                      hsum;
  logic [63:0]                      trig_rnd;
  logic [32:0]                      trig_q;
  logic [15:0]                      trig_mag;
  logic [15:0]                      trig_v;
  logic [63:0]                      pos_rnd;
  logic signed [32:0]               delta;
  logic signed [31:0]               pos_cur;
  logic signed [33:0]               pos_sum;
  logic signed [31:0]               pos_sat;
  logic [21:0]                      speed_slew;
  logic [21:0]                      turn_slew;

  assign in_xfer = in_tvalid && in_tready;

  // Shared multiplier
  assign prod = a_r * b_r;

  // Table index and sign for the current axis
  assign angle = heading_r + (axis_r ? 16'd0 : slui_pkg::QUARTER);
  assign phase = angle[13 -: slui_pkg::SINE_TABLE_BITS];
  assign idx   = angle[14] ? (slui_pkg::SINE_N - {1'b0, phase}) : {1'b0, phase};

  // Squared index rescaled into Q30
  assign sq_ext = {30'd0, p_r};
  assign x2_w   = 31'((sq_ext << slui_pkg::X2_SHL) >> 30);

  // Heading step, rounded
  assign hsum = p_r[31:0] + 32'h0000_8000;

  // Q1.15 sine with rounding, clamp and quadrant sign
  assign trig_rnd = p_r + 64'sd536870912;
  assign trig_q   = trig_rnd[62:30];
  assign trig_mag = (trig_q > 33'(slui_pkg::TRIG_MAX)) ? {1'b0, slui_pkg::TRIG_MAX}
                                                       : trig_q[15:0];
  assign trig_v   = neg_r ? (16'd0 - trig_mag) : trig_mag;

  // Position step, rounded to nearest, and saturating add
  assign pos_rnd = p_r + 64'sd16777216;
  assign delta   = $signed(pos_rnd[57:25]);
  assign pos_cur = axis_r ? pos_y_r : pos_x_r;
  assign pos_sum = {{2{pos_cur[31]}}, pos_cur} + {delta[32], delta};
  always_comb begin
    if (pos_sum[33:31] == 3'b000 || pos_sum[33:31] == 3'b111) begin
      pos_sat = pos_sum[31:0];
    end else if (pos_sum[33]) begin
      pos_sat = 32'sh8000_0000;
    end else begin
      pos_sat = 32'sh7FFF_FFFF;
    end
  end

  // Slewed velocities from the incoming command
  assign speed_slew = slew($signed({{6{speed_r[15]}}, speed_r}),
                           $signed({{6{in_tdata[15]}}, in_tdata[15:0]}),
                           $signed({7'd0, speed_step_r}));
  assign turn_slew  = slew($signed({{2{turn_r[19]}}, turn_r}),
                           $signed({{2{in_tdata[35]}}, in_tdata[35:16]}),
                           $signed({3'd0, turn_step_r}));

  // --------------------------------------------------------------------------
  // Sequencer: next state and register updates
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    speed_step_nxt = speed_step_r;
    turn_step_nxt  = turn_step_r;
    tick_nxt       = tick_r;
    pos_x_nxt      = pos_x_r;
    pos_y_nxt      = pos_y_r;
    heading_nxt    = heading_r;
    speed_nxt      = speed_r;
    turn_nxt       = turn_r;
    axis_nxt       = axis_r;
    neg_nxt        = neg_r;
    x_nxt          = x_r;
    x2_nxt         = x2_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;

    // Take configuration writes at any time
    if (cfg_wr_en) begin
      unique case (cfg_addr)
        slui_pkg::CFG_SPEED_STEP:   speed_step_nxt = cfg_wdata[14:0];
        slui_pkg::CFG_TURN_STEP:    turn_step_nxt  = cfg_wdata[18:0];
        slui_pkg::CFG_TICK_SECONDS: tick_nxt       = cfg_wdata[15:0];
        default: ;
      endcase
    end

    unique case (state_r)
      slui_pkg::ST_IDLE: begin
        // Slew velocities and start the heading product
        if (in_xfer) begin
          speed_nxt = speed_slew[15:0];
          turn_nxt  = turn_slew[19:0];
          a_nxt     = sext({{12{turn_slew[19]}}, turn_slew[19:0]});
          b_nxt     = uext({16'd0, tick_r});
          axis_nxt  = 1'b0;
          state_nxt = slui_pkg::ST_HMUL;
        end
      end
      slui_pkg::ST_HMUL: state_nxt = slui_pkg::ST_HUPD;
      slui_pkg::ST_HUPD: begin
        heading_nxt = heading_r + hsum[31:16];
        state_nxt   = slui_pkg::ST_IDX;
      end
      slui_pkg::ST_IDX: begin
        // Square the table index
        a_nxt     = uext(32'(idx));
        b_nxt     = uext(32'(idx));
        x_nxt     = 31'(idx) << slui_pkg::X_SHL;
        neg_nxt   = angle[15];
        state_nxt = slui_pkg::ST_SQ;
      end
      slui_pkg::ST_SQ: state_nxt = slui_pkg::ST_LDC;
      slui_pkg::ST_LDC: begin
        x2_nxt    = x2_w;
        a_nxt     = uext(slui_pkg::Q30_C);
        b_nxt     = uext({1'b0, x2_w});
        state_nxt = slui_pkg::ST_MC;
      end
      slui_pkg::ST_MC: state_nxt = slui_pkg::ST_LDB;
      slui_pkg::ST_LDB: begin
        a_nxt     = uext(slui_pkg::Q30_B - p_r[61:30]);
        b_nxt     = uext({1'b0, x2_r});
        state_nxt = slui_pkg::ST_MB;
      end
      slui_pkg::ST_MB: state_nxt = slui_pkg::ST_LDA;
      slui_pkg::ST_LDA: begin
        a_nxt     = uext(slui_pkg::Q30_A - p_r[61:30]);
        b_nxt     = uext({1'b0, x_r});
        state_nxt = slui_pkg::ST_MA;
      end
      slui_pkg::ST_MA: state_nxt = slui_pkg::ST_LDR;
      slui_pkg::ST_LDR: begin
        // Scale the Q30 sine to Q1.15
        a_nxt     = uext(p_r[61:30]);
        b_nxt     = uext({17'd0, slui_pkg::TRIG_MAX});
        state_nxt = slui_pkg::ST_MR;
      end
      slui_pkg::ST_MR: state_nxt = slui_pkg::ST_LDV;
      slui_pkg::ST_LDV: begin
        a_nxt     = sext({{16{speed_r[15]}}, speed_r});
        b_nxt     = sext({{16{trig_v[15]}}, trig_v});
        state_nxt = slui_pkg::ST_MV;
      end
      slui_pkg::ST_MV: state_nxt = slui_pkg::ST_LDT;
      slui_pkg::ST_LDT: begin
        a_nxt     = $signed(p_r[32:0]);
        b_nxt     = uext({16'd0, tick_r});
        state_nxt = slui_pkg::ST_MT;
      end
      slui_pkg::ST_MT: state_nxt = slui_pkg::ST_POS;
      slui_pkg::ST_POS: begin
        // Advance one axis, then the other
        if (axis_r) begin
          pos_y_nxt = pos_sat;
          state_nxt = slui_pkg::ST_OUT;
        end else begin
          pos_x_nxt = pos_sat;
          axis_nxt  = 1'b1;
          state_nxt = slui_pkg::ST_IDX;
        end
      end
      slui_pkg::ST_OUT: begin
        // Hold until the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_tdata_nxt  = {4'd0, turn_r, speed_r, heading_r, pos_y_r, pos_x_r};
          out_tvalid_nxt = 1'b1;
          state_nxt      = slui_pkg::ST_IDLE;
        end
      end
      default: state_nxt = slui_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Clocked state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= slui_pkg::ST_IDLE;
      speed_step_r <= slui_pkg::SPEED_STEP_RST;
      turn_step_r  <= slui_pkg::TURN_STEP_RST;
      tick_r       <= slui_pkg::TICK_SECONDS_RST;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      heading_r    <= '0;
      speed_r      <= '0;
      turn_r       <= '0;
      axis_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      speed_step_r <= speed_step_nxt;
      turn_step_r  <= turn_step_nxt;
      tick_r       <= tick_nxt;
      pos_x_r      <= pos_x_nxt;
      pos_y_r      <= pos_y_nxt;
      heading_r    <= heading_nxt;
      speed_r      <= speed_nxt;
      turn_r       <= turn_nxt;
      axis_r       <= axis_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    neg_r       <= neg_nxt;
    x_r         <= x_nxt;
    x2_r        <= x2_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    p_r         <= prod[slui_pkg::PROD_W-1:0];
    out_tdata_r <= out_tdata_nxt;
  end

  assign in_tready  = (state_r == slui_pkg::ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_vel_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_xfer |=> $stable(speed_r) && $stable(turn_r))
    else $error("velocity changed without an input transfer");

  a_both_axes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slui_pkg::ST_OUT) |-> axis_r)
    else $error("result issued before both axes were advanced");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == slui_pkg::ST_OUT))
    else $error("result raised outside the output step");

endmodule
